// ----- hdl/fcdc_pkg.sv -----
// Shared types and constants for the fixed calendar day conversion block.
// Holds the pipeline depth, the conversion selector, calendar constants and reciprocal multipliers.
// No dependencies; every other file imports this package.
package fcdc_pkg;

  // Pipeline depth and stage count of the date-to-day-number path.
  localparam int NSTAGE     = 9;
  localparam int F2D_STAGES = 4;

  // Stream payload widths.
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 2;

  // Conversion selector carried on in_tuser.
  typedef enum logic {
    TO_DATE       = 1'b0,
    TO_DAY_NUMBER = 1'b1
  } fcdc_func_t;

  // Calendar constants.
  localparam logic [22:0] EPOCH_JDN       = 23'd1721426;
  localparam logic [17:0] DAYS_400Y       = 18'd146097;
  localparam logic [15:0] DAYS_100Y       = 16'd36524;
  localparam logic [10:0] DAYS_4Y         = 11'd1461;
  localparam logic [8:0]  DAYS_COMMON     = 9'd365;
  localparam logic [8:0]  DAYS_LEAP       = 9'd366;
  localparam logic [8:0]  LEAP_DAY_ORD    = 9'd169;
  localparam logic [8:0]  ORD_BEFORE_LEAP = 9'd168;
  localparam logic [8:0]  LAST_ORD_M1     = 9'd364;
  localparam logic [4:0]  MONTH_DAYS      = 5'd28;
  localparam logic [4:0]  SPECIAL_DAY     = 5'd29;
  localparam logic [3:0]  LAST_MONTH      = 4'd13;
  localparam logic [3:0]  LEAP_MONTH      = 4'd6;
  localparam logic [6:0]  CENTURY_YEARS   = 7'd100;

  // Exact reciprocal multipliers: q = (x * RECIP) >> SHIFT for the full input range.
  localparam int          SHIFT_400Y = 41;
  localparam logic [23:0] RECIP_400Y =
    24'(((64'd1 << SHIFT_400Y) + 64'd146097 - 64'd1) / 64'd146097);
  localparam int          SHIFT_4Y   = 27;
  localparam logic [16:0] RECIP_4Y   =
    17'(((64'd1 << SHIFT_4Y) + 64'd1461 - 64'd1) / 64'd1461);
  localparam int          SHIFT_CENT = 21;
  localparam logic [14:0] RECIP_CENT =
    15'(((64'd1 << SHIFT_CENT) + 64'd100 - 64'd1) / 64'd100);
  localparam int          SHIFT_MON  = 14;
  localparam logic [9:0]  RECIP_MON  =
    10'(((64'd1 << SHIFT_MON) + 64'd28 - 64'd1) / 64'd28);

  // Per-stage load enables from the pipeline control.
  typedef logic [NSTAGE-1:0] fcdc_load_t;

  // Result of the day-number-to-date path.
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        special;
    logic        bad;
  } fcdc_date_t;

  // Result of the date-to-day-number path.
  typedef struct packed {
    logic [22:0] day_number;
    logic        special;
    logic        bad;
  } fcdc_jdn_t;

endpackage

// ----- hdl/fcdc_ctrl.sv -----
// Pipeline control: valid bits per stage and the per-stage load enables.
// A stage loads when it is empty or the stage after it loads, so bubbles collapse.
// Depends on fcdc_pkg.
module fcdc_ctrl
  import fcdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output fcdc_load_t load
);

  logic [NSTAGE-1:0] valid_r;
  logic [NSTAGE-1:0] valid_nxt;
  fcdc_load_t        load_c;

  // Load enables ripple back from the output register.
  always_comb begin
    load_c[NSTAGE-1] = !valid_r[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      load_c[k] = !valid_r[k] || load_c[k+1];
    end
  end

  // Valid bits move with the data of each stage.
  always_comb begin
    valid_nxt[0] = load_c[0] ? in_valid : valid_r[0];
    for (int k = 1; k < NSTAGE; k++) begin
      valid_nxt[k] = load_c[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign load      = load_c;
  assign in_ready  = load_c[0];
  assign out_valid = valid_r[NSTAGE-1];

endmodule

// ----- hdl/fcdc_d2f.sv -----
// Day number to fixed date path: nine register stages of divide-by-constant steps.
// Splits the day count into 400, 100, 4 and 1 year cycles, then into months.
// Depends on fcdc_pkg.
module fcdc_d2f
  import fcdc_pkg::*;
#(
  parameter int MAX_YEAR = 9999
) (
  input  logic        clk,
  input  fcdc_load_t  load,
  input  logic [22:0] jdn,
  output fcdc_date_t  result
);

  localparam longint unsigned MAX_L  = 64'(MAX_YEAR);
  localparam longint unsigned LAST_L =
    64'd1721426 + 64'd365 * MAX_L + MAX_L / 64'd4 - MAX_L / 64'd100 + MAX_L / 64'd400 - 64'd1;
  localparam logic [31:0] LAST_JDN = 32'(LAST_L);

  // Stage 1: offset from the epoch and range check.
  logic [22:0] s1_d_r;
  logic        s1_bad_r;
  always_ff @(posedge clk) begin
    if (load[0]) begin
      s1_d_r   <= jdn - EPOCH_JDN;
      s1_bad_r <= (jdn < EPOCH_JDN) || ({9'd0, jdn} > LAST_JDN);
    end
  end

  // Stage 2: number of whole 400-year cycles.
  logic [46:0] prod400;
  logic [22:0] s2_d_r;
  logic [5:0]  s2_q_r;
  logic        s2_bad_r;
  assign prod400 = 47'(s1_d_r) * 47'(RECIP_400Y);
  always_ff @(posedge clk) begin
    if (load[1]) begin
      s2_d_r   <= s1_d_r;
      s2_q_r   <= prod400[46:41];
      s2_bad_r <= s1_bad_r;
    end
  end

  // Stage 3: days left in the 400-year cycle.
  logic [22:0] rem400;
  logic [17:0] s3_r_r;
  logic [5:0]  s3_n400_r;
  logic        s3_bad_r;
  assign rem400 = s2_d_r - 23'(23'(s2_q_r) * 23'(DAYS_400Y));
  always_ff @(posedge clk) begin
    if (load[2]) begin
      s3_r_r    <= rem400[17:0];
      s3_n400_r <= s2_q_r;
      s3_bad_r  <= s2_bad_r;
    end
  end

  // Stage 4: centuries, capped at three so the last day of the cycle stays in it.
  logic [1:0]  n100;
  logic [17:0] rem100;
  always_comb begin
    if (s3_r_r >= 18'(3 * 36524)) begin
      n100 = 2'd3;
    end else if (s3_r_r >= 18'(2 * 36524)) begin
      n100 = 2'd2;
    end else if (s3_r_r >= 18'(DAYS_100Y)) begin
      n100 = 2'd1;
    end else begin
      n100 = 2'd0;
    end
    rem100 = s3_r_r - 18'(18'(n100) * 18'(DAYS_100Y));
  end

  logic [15:0] s4_r_r;
  logic [5:0]  s4_n400_r;
  logic [1:0]  s4_n100_r;
  logic        s4_bad_r;
  always_ff @(posedge clk) begin
    if (load[3]) begin
      s4_r_r    <= rem100[15:0];
      s4_n400_r <= s3_n400_r;
      s4_n100_r <= n100;
      s4_bad_r  <= s3_bad_r;
    end
  end

  // Stage 5: number of whole 4-year cycles.
  logic [32:0] prod4;
  logic [15:0] s5_r_r;
  logic [4:0]  s5_n4_r;
  logic [5:0]  s5_n400_r;
  logic [1:0]  s5_n100_r;
  logic        s5_bad_r;
  assign prod4 = 33'(s4_r_r) * 33'(RECIP_4Y);
  always_ff @(posedge clk) begin
    if (load[4]) begin
      s5_r_r    <= s4_r_r;
      s5_n4_r   <= 5'(prod4[32:27]);
      s5_n400_r <= s4_n400_r;
      s5_n100_r <= s4_n100_r;
      s5_bad_r  <= s4_bad_r;
    end
  end

  // Stage 6: days left in the 4-year cycle.
  logic [15:0] rem4;
  logic [10:0] s6_r_r;
  logic [4:0]  s6_n4_r;
  logic [5:0]  s6_n400_r;
  logic [1:0]  s6_n100_r;
  logic        s6_bad_r;
  assign rem4 = s5_r_r - 16'(16'(s5_n4_r) * 16'(DAYS_4Y));
  always_ff @(posedge clk) begin
    if (load[5]) begin
      s6_r_r    <= rem4[10:0];
      s6_n4_r   <= s5_n4_r;
      s6_n400_r <= s5_n400_r;
      s6_n100_r <= s5_n100_r;
      s6_bad_r  <= s5_bad_r;
    end
  end

  // Stage 7: single years, the year itself, its leap flag and the day of year.
  logic [1:0]  n1;
  logic [10:0] rem1;
  logic [14:0] year_c;
  logic        leap_c;
  always_comb begin
    if (s6_r_r >= 11'(3 * 365)) begin
      n1 = 2'd3;
    end else if (s6_r_r >= 11'(2 * 365)) begin
      n1 = 2'd2;
    end else if (s6_r_r >= 11'(DAYS_COMMON)) begin
      n1 = 2'd1;
    end else begin
      n1 = 2'd0;
    end
    rem1   = s6_r_r - 11'(11'(n1) * 11'(DAYS_COMMON));
    year_c = 15'(15'(s6_n400_r) * 15'd400) + 15'(15'(s6_n100_r) * 15'd100)
           + 15'(15'(s6_n4_r) * 15'd4) + 15'(n1) + 15'd1;
    // Leap when the year is a multiple of four, except plain century years.
    leap_c = (n1 == 2'd3) && ((s6_n4_r != 5'd24) || (s6_n100_r == 2'd3));
  end

  logic [14:0] s7_year_r;
  logic [8:0]  s7_x_r;
  logic        s7_leap_r;
  logic        s7_bad_r;
  always_ff @(posedge clk) begin
    if (load[6]) begin
      s7_year_r <= year_c;
      s7_x_r    <= rem1[8:0];
      s7_leap_r <= leap_c;
      s7_bad_r  <= s6_bad_r;
    end
  end

  // Stage 8: special days, drop Leap Day from the count, month quotient.
  logic        leap_day;
  logic [8:0]  x_adj;
  logic        year_day;
  logic [18:0] prod_mon;
  always_comb begin
    leap_day = s7_leap_r && (s7_x_r == ORD_BEFORE_LEAP);
    x_adj    = (s7_leap_r && (s7_x_r > ORD_BEFORE_LEAP)) ? s7_x_r - 9'd1 : s7_x_r;
    year_day = !leap_day && (x_adj == LAST_ORD_M1);
    prod_mon = 19'(x_adj) * 19'(RECIP_MON);
  end

  logic [14:0] s8_year_r;
  logic [8:0]  s8_x_r;
  logic [3:0]  s8_mq_r;
  logic        s8_leap_day_r;
  logic        s8_year_day_r;
  logic        s8_bad_r;
  always_ff @(posedge clk) begin
    if (load[7]) begin
      s8_year_r     <= s7_year_r;
      s8_x_r        <= x_adj;
      s8_mq_r       <= 4'(prod_mon[18:14]);
      s8_leap_day_r <= leap_day;
      s8_year_day_r <= year_day;
      s8_bad_r      <= s7_bad_r;
    end
  end

  // Stage 9: month and day, special-day overrides, zeroed fields on error.
  logic [8:0] day_full;
  fcdc_date_t res_nxt;
  always_comb begin
    day_full = s8_x_r - 9'(9'(s8_mq_r) * 9'(MONTH_DAYS)) + 9'd1;
    res_nxt  = '0;
    if (s8_bad_r) begin
      res_nxt.bad = 1'b1;
    end else begin
      res_nxt.year = s8_year_r[13:0];
      if (s8_leap_day_r) begin
        res_nxt.month   = LEAP_MONTH;
        res_nxt.day     = SPECIAL_DAY;
        res_nxt.special = 1'b1;
      end else if (s8_year_day_r) begin
        res_nxt.month   = LAST_MONTH;
        res_nxt.day     = SPECIAL_DAY;
        res_nxt.special = 1'b1;
      end else begin
        res_nxt.month = s8_mq_r + 4'd1;
        res_nxt.day   = day_full[4:0];
      end
    end
  end

  fcdc_date_t result_r;
  always_ff @(posedge clk) begin
    if (load[8]) begin
      result_r <= res_nxt;
    end
  end

  assign result = result_r;

endmodule

// ----- hdl/fcdc_f2d.sv -----
// Fixed date to day number path: four working stages and a delay line to full depth.
// Checks the date, finds the day of year and the day number of January 1.
// Depends on fcdc_pkg.
module fcdc_f2d
  import fcdc_pkg::*;
#(
  parameter int MAX_YEAR = 9999
) (
  input  logic        clk,
  input  fcdc_load_t  load,
  input  logic [13:0] fixed_year,
  input  logic [3:0]  fixed_month,
  input  logic [4:0]  fixed_day,
  output fcdc_jdn_t   result
);

  localparam logic [31:0] MAX_YEAR_W = 32'(MAX_YEAR);
  localparam int          DLY        = NSTAGE - F2D_STAGES;

  // Stage 1: field range checks and the century quotient of the year.
  logic [28:0] prod_cent;
  logic        ok0;
  assign prod_cent = 29'(fixed_year) * 29'(RECIP_CENT);
  assign ok0 = (fixed_year != 14'd0) && ({18'd0, fixed_year} <= MAX_YEAR_W)
            && (fixed_month != 4'd0) && (fixed_month <= LAST_MONTH)
            && (fixed_day != 5'd0);

  logic [13:0] s1_fy_r;
  logic [3:0]  s1_fm_r;
  logic [4:0]  s1_fd_r;
  logic [7:0]  s1_q100_r;
  logic        s1_ok_r;
  always_ff @(posedge clk) begin
    if (load[0]) begin
      s1_fy_r   <= fixed_year;
      s1_fm_r   <= fixed_month;
      s1_fd_r   <= fixed_day;
      s1_q100_r <= prod_cent[28:21];
      s1_ok_r   <= ok0;
    end
  end

  // Stage 2: leap year, day 29 check, day of year and the year divisions.
  logic [13:0] cent_rem;
  logic        z100;
  logic        z400;
  logic        leap;
  logic        day_ok;
  logic [8:0]  ord_plain;
  logic [8:0]  ord_c;
  logic        special_c;
  always_comb begin
    cent_rem  = s1_fy_r - 14'(14'(s1_q100_r) * 14'(CENTURY_YEARS));
    z100      = (cent_rem == 14'd0);
    z400      = z100 && (s1_q100_r[1:0] == 2'd0);
    leap      = (s1_fy_r[1:0] == 2'd0) && (!z100 || z400);
    day_ok    = (s1_fd_r <= MONTH_DAYS)
             || ((s1_fd_r == SPECIAL_DAY)
                 && ((s1_fm_r == LAST_MONTH) || ((s1_fm_r == LEAP_MONTH) && leap)));
    ord_plain = 9'(9'(s1_fm_r - 4'd1) * 9'(MONTH_DAYS)) + 9'(s1_fd_r);
    special_c = 1'b0;
    if ((s1_fm_r == LEAP_MONTH) && (s1_fd_r == SPECIAL_DAY)) begin
      ord_c     = LEAP_DAY_ORD;
      special_c = 1'b1;
    end else if ((s1_fm_r == LAST_MONTH) && (s1_fd_r == SPECIAL_DAY)) begin
      ord_c     = leap ? DAYS_LEAP : DAYS_COMMON;
      special_c = 1'b1;
    end else if (leap && (ord_plain > ORD_BEFORE_LEAP)) begin
      ord_c = ord_plain + 9'd1;
    end else begin
      ord_c = ord_plain;
    end
  end

  logic [13:0] s2_p_r;
  logic [11:0] s2_pd4_r;
  logic [7:0]  s2_pd100_r;
  logic [5:0]  s2_pd400_r;
  logic [8:0]  s2_ord_r;
  logic        s2_special_r;
  logic        s2_ok_r;
  logic [13:0] p_c;
  assign p_c = s1_fy_r - 14'd1;
  always_ff @(posedge clk) begin
    if (load[1]) begin
      s2_p_r       <= p_c;
      s2_pd4_r     <= p_c[13:2];
      s2_pd100_r   <= s1_q100_r - 8'(z100);
      s2_pd400_r   <= s1_q100_r[7:2] - 6'(z400);
      s2_ord_r     <= ord_c;
      s2_special_r <= special_c;
      s2_ok_r      <= s1_ok_r && day_ok;
    end
  end

  // Stage 3: January 1 base and a small signed correction.
  logic [23:0] base_c;
  logic [9:0]  corr_c;
  assign base_c = 24'(EPOCH_JDN) + 24'(24'(s2_p_r) * 24'(DAYS_COMMON)) + 24'(s2_pd4_r);
  assign corr_c = 10'(s2_ord_r) - 10'd1 - 10'(s2_pd100_r) + 10'(s2_pd400_r);

  logic [23:0] s3_base_r;
  logic [9:0]  s3_corr_r;
  logic        s3_special_r;
  logic        s3_ok_r;
  always_ff @(posedge clk) begin
    if (load[2]) begin
      s3_base_r    <= base_c;
      s3_corr_r    <= corr_c;
      s3_special_r <= s2_special_r;
      s3_ok_r      <= s2_ok_r;
    end
  end

  // Stage 4: final day number and overflow check.
  logic [23:0] sum_c;
  logic        bad_c;
  fcdc_jdn_t   res_nxt;
  always_comb begin
    sum_c   = s3_base_r + {{14{s3_corr_r[9]}}, s3_corr_r};
    bad_c   = !s3_ok_r || sum_c[23];
    res_nxt = '0;
    if (bad_c) begin
      res_nxt.bad = 1'b1;
    end else begin
      res_nxt.day_number = sum_c[22:0];
      res_nxt.special    = s3_special_r;
    end
  end

  fcdc_jdn_t s4_res_r;
  always_ff @(posedge clk) begin
    if (load[3]) begin
      s4_res_r <= res_nxt;
    end
  end

  // Delay line so this path lines up with the other one.
  fcdc_jdn_t dly_r [DLY];
  always_ff @(posedge clk) begin
    if (load[F2D_STAGES]) begin
      dly_r[0] <= s4_res_r;
    end
    for (int k = 1; k < DLY; k++) begin
      if (load[F2D_STAGES + k]) begin
        dly_r[k] <= dly_r[k-1];
      end
    end
  end

  assign result = dly_r[DLY-1];

endmodule

// ----- hdl/fixed_calendar_day_conversion.sv -----
// Fixed calendar day conversion.
// Use: each request on the in_ stream carries a selector in in_tuser. A zero
// selector converts the Julian day number in in_tdata to a fixed calendar date
// (year, month 1-13, day 1-29); a one converts the fixed date in in_tdata to a
// Julian day number. Every request gives exactly one result on the out_ stream.
// out_tuser flags Leap Day or Year Day and a bad input; on a bad input all other
// result fields are zero. Fields of the conversion not asked for are zero.
// Throughput: one request per cycle while the output is not stalled; both conversions run side by side through
// a nine-stage pipeline whose depth is set by the chain of constant divisions
// (400, 100, 4 and 1 year cycles, then months) of the day-number path.
// Stalls: when out_tready is low the result holds on out_tdata; stages behind
// it keep accepting until the pipeline is full, so bubbles are squeezed out.
// in_tready is low only when every stage holds a pending request.
// Reset: rst_n is synchronous and active low; it empties the pipeline and no
// result is in flight after it. The block keeps no state between requests.
// Depends on fcdc_pkg, fcdc_ctrl, fcdc_d2f and fcdc_f2d.
module fixed_calendar_day_conversion
  import fcdc_pkg::*;
#(
  parameter int MAX_YEAR = 9999
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // day_number[22:0], fixed_year[36:23], fixed_month[40:37], fixed_day[45:41], zero[47:46]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_year[13:0], out_month[17:14], out_day[22:18], out_day_number[45:23], zero[47:46]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // special_day[0], bad_input[1]
  output logic [OUT_USER_W-1:0] out_tuser
);

  fcdc_load_t load;
  fcdc_date_t date_res;
  fcdc_jdn_t  jdn_res;

  fcdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .load      (load)
  );

  fcdc_d2f #(
    .MAX_YEAR (MAX_YEAR)
  ) u_d2f (
    .clk    (clk),
    .load   (load),
    .jdn    (in_tdata[22:0]),
    .result (date_res)
  );

  fcdc_f2d #(
    .MAX_YEAR (MAX_YEAR)
  ) u_f2d (
    .clk         (clk),
    .load        (load),
    .fixed_year  (in_tdata[36:23]),
    .fixed_month (in_tdata[40:37]),
    .fixed_day   (in_tdata[45:41]),
    .result      (jdn_res)
  );

  // The selector travels alongside the two conversion paths.
  logic func_r [NSTAGE];
  always_ff @(posedge clk) begin
    if (load[0]) begin
      func_r[0] <= in_tuser;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (load[k]) begin
        func_r[k] <= func_r[k-1];
      end
    end
  end

  // Pick the requested conversion; the other one's fields read as zero.
  always_comb begin
    out_tdata = '0;
    out_tuser = '0;
    if (func_r[NSTAGE-1] == TO_DAY_NUMBER) begin
      out_tdata[45:23] = jdn_res.day_number;
      out_tuser[0]     = jdn_res.special;
      out_tuser[1]     = jdn_res.bad;
    end else begin
      out_tdata[13:0]  = date_res.year;
      out_tdata[17:14] = date_res.month;
      out_tdata[22:18] = date_res.day;
      out_tuser[0]     = date_res.special;
      out_tuser[1]     = date_res.bad;
    end
  end

endmodule

// ----- hdl/fcdc_chk.sv -----
// Port-level checker for the fixed calendar day conversion block, with its bind.
// Watches only the top level's stream ports.
// Depends on fcdc_pkg and fixed_calendar_day_conversion.
module fcdc_chk
  import fcdc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  // A result stalled by the receiver holds still.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Reset leaves no result in flight.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A bad input gives an all-zero result without the special flag.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> (out_tdata == '0) && !out_tuser[0])
    else $error("bad input result carries data");

  // A valid date result has month 1-13, day 1-29, and special days read day 29.
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] && (out_tdata[45:23] == 23'd0)
    |-> (out_tdata[17:14] != 4'd0) && (out_tdata[17:14] <= LAST_MONTH)
        && (out_tdata[22:18] != 5'd0) && (out_tdata[22:18] <= SPECIAL_DAY)
        && (!out_tuser[0] || (out_tdata[22:18] == SPECIAL_DAY)))
    else $error("date result out of range");

endmodule

bind fixed_calendar_day_conversion fcdc_chk u_fcdc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
